// ===== design/emg_td_pkg.sv =====
// Shared types and constants for the EMG time-domain feature extractor.
`default_nettype none
package emg_td_pkg;

    localparam int CHANNELS  = 8;
    localparam int SAMPLE_W  = 16;
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int MAG_W     = SAMPLE_W + 1;
    localparam int LABEL_W   = 8;
    localparam int WIDTH_W   = 12;
    localparam int CHAN_W    = 3;
    localparam int ABS_W     = 27;
    localparam int COUNT_W   = 12;
    localparam int LEN_ACC_W = 29;
    localparam int LEN_OUT_W = 28;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [WIDTH_W-1:0] WINDOW_WIDTH_RESET = 12'd200;

    // Register index, taken from the word-address bit of paddr.
    localparam logic REG_WINDOW_WIDTH = 1'b0;

    // Per-step control shared by all lanes.
    typedef struct packed {
        logic accept;
        logic has_prev;
        logic has_prev_diff;
        logic close;
    } lane_ctrl_t;

    // Window features of one channel.
    typedef struct packed {
        logic [ABS_W-1:0]     abs_sum;
        logic [COUNT_W-1:0]   same_sign_count;
        logic [LEN_OUT_W-1:0] wave_length;
        logic [COUNT_W-1:0]   same_slope_count;
    } feat_t;

endpackage
`default_nettype wire

// ===== design/emg_td_lane.sv =====
// One channel lane: neighbor tests and the four running window sums.
`default_nettype none
module emg_td_lane (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire emg_td_pkg::lane_ctrl_t                ctrl,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample,
    output emg_td_pkg::feat_t                          result
);
    import emg_td_pkg::*;

    logic signed [SAMPLE_W-1:0] prev_sample_reg;
    logic signed [DIFF_W-1:0]   prev_diff_reg;
    logic [ABS_W-1:0]           abs_reg;
    logic [COUNT_W-1:0]         sign_reg;
    logic [LEN_ACC_W-1:0]       len_reg;
    logic [COUNT_W-1:0]         slope_reg;

    logic [DIFF_W-1:0]    x_ext;
    logic [DIFF_W-1:0]    x_neg;
    logic [MAG_W-1:0]     mag_x;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]    diff_neg;
    logic [MAG_W-1:0]     mag_d;
    logic                 sign_hit;
    logic                 slope_hit;
    logic [ABS_W-1:0]     abs_next;
    logic [COUNT_W-1:0]   sign_next;
    logic [LEN_ACC_W-1:0] len_next;
    logic [COUNT_W-1:0]   slope_next;

    always_comb
    begin
        x_ext    = {sample[SAMPLE_W-1], sample};
        x_neg    = -x_ext;
        mag_x    = sample[SAMPLE_W-1] ? x_neg[MAG_W-1:0] : x_ext[MAG_W-1:0];
        diff     = $signed(x_ext) - $signed({prev_sample_reg[SAMPLE_W-1], prev_sample_reg});
        diff_neg = -diff;
        mag_d    = diff[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];

        // A product is positive when both factors are nonzero and share a sign.
        sign_hit  = ctrl.has_prev && (sample != '0) && (prev_sample_reg != '0)
                    && (sample[SAMPLE_W-1] == prev_sample_reg[SAMPLE_W-1]);
        slope_hit = ctrl.has_prev_diff && (diff != '0) && (prev_diff_reg != '0)
                    && (diff[DIFF_W-1] == prev_diff_reg[DIFF_W-1]);

        abs_next   = abs_reg + ABS_W'(mag_x);
        sign_next  = sign_hit ? sign_reg + 1'b1 : sign_reg;
        len_next   = ctrl.has_prev ? len_reg + LEN_ACC_W'(mag_d) : len_reg;
        slope_next = slope_hit ? slope_reg + 1'b1 : slope_reg;

        result.abs_sum          = abs_next;
        result.same_sign_count  = sign_next;
        result.wave_length      = len_next[LEN_OUT_W-1:0];
        result.same_slope_count = slope_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            prev_diff_reg   <= '0;
            abs_reg         <= '0;
            sign_reg        <= '0;
            len_reg         <= '0;
            slope_reg       <= '0;
        end
        else if (ctrl.accept)
        begin
            prev_sample_reg <= sample;
            if (ctrl.has_prev)
            begin
                prev_diff_reg <= diff;
            end
            if (ctrl.close)
            begin
                abs_reg   <= '0;
                sign_reg  <= '0;
                len_reg   <= '0;
                slope_reg <= '0;
            end
            else
            begin
                abs_reg   <= abs_next;
                sign_reg  <= sign_next;
                len_reg   <= len_next;
                slope_reg <= slope_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/emg_td_drain.sv =====
// Merge stage: captures all lane results of a closed window and sends them out in channel order.
`default_nettype none
module emg_td_drain (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire emg_td_pkg::feat_t                  feats [emg_td_pkg::CHANNELS],
    input  wire logic [emg_td_pkg::LABEL_W-1:0]     label,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [emg_td_pkg::CHAN_W-1:0]           channel,
    output logic [emg_td_pkg::ABS_W-1:0]            abs_sum,
    output logic [emg_td_pkg::COUNT_W-1:0]          same_sign_count,
    output logic [emg_td_pkg::LEN_OUT_W-1:0]        wave_length,
    output logic [emg_td_pkg::COUNT_W-1:0]          same_slope_count,
    output logic [emg_td_pkg::LABEL_W-1:0]          window_label,
    output logic                                    last
);
    import emg_td_pkg::*;

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

    feat_t               buf_reg [CHANNELS];
    logic [LABEL_W-1:0]  label_reg;
    logic [CHAN_W-1:0]   cnt_reg;
    logic                valid_reg;
    logic                take;

    assign take = valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            if (cnt_reg == LAST_CHAN)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // The head of the shift line is always the channel being offered.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg   <= feats;
            label_reg <= label;
        end
        else if (take)
        begin
            for (int i = 0; i < CHANNELS - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

    always_comb
    begin
        out_valid        = valid_reg;
        channel          = cnt_reg;
        abs_sum          = buf_reg[0].abs_sum;
        same_sign_count  = buf_reg[0].same_sign_count;
        wave_length      = buf_reg[0].wave_length;
        same_slope_count = buf_reg[0].same_slope_count;
        window_label     = label_reg;
        last             = (cnt_reg == LAST_CHAN);
    end

endmodule
`default_nettype wire

// ===== design/emg_time_domain_features.sv =====
// Top level of the EMG time-domain feature extractor.
// The first result of a window appears in the cycle after its closing step is accepted,
// the other seven follow one per cycle while the receiver does not stall.
// Throughput: one time step per cycle while window_width is at least the channel count (8)
// and the receiver does not stall; a window closing while the previous window's results still
// drain waits for the drain, so narrower windows can stall the sample channel (width zero counts as one).
// Reset: asynchronous, active low; clears all sums, the step position and the held label.
`default_nettype none
module emg_time_domain_features (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [emg_td_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [emg_td_pkg::DATA_W-1:0]      pwdata,
    output logic [emg_td_pkg::DATA_W-1:0]           prdata,
    output logic                                    pready,
    // Sample channel.
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch0,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch1,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch2,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch3,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch4,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch5,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch6,
    input  wire logic signed [emg_td_pkg::SAMPLE_W-1:0] sample_ch7,
    input  wire logic [emg_td_pkg::LABEL_W-1:0]     class_label,
    // Feature channel.
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [emg_td_pkg::CHAN_W-1:0]           channel,
    output logic [emg_td_pkg::ABS_W-1:0]            abs_sum,
    output logic [emg_td_pkg::COUNT_W-1:0]          same_sign_count,
    output logic [emg_td_pkg::LEN_OUT_W-1:0]        wave_length,
    output logic [emg_td_pkg::COUNT_W-1:0]          same_slope_count,
    output logic [emg_td_pkg::LABEL_W-1:0]          window_label,
    output logic                                    last
);
    import emg_td_pkg::*;

    logic [WIDTH_W-1:0] window_width_reg;
    logic [WIDTH_W-1:0] pos_reg;
    logic [WIDTH_W-1:0] pos_next;
    logic [LABEL_W-1:0] held_label_reg;

    logic [WIDTH_W-1:0] width_eff;
    logic               close;
    logic               mid;
    logic               in_accept;
    logic               drain_free;
    logic [LABEL_W-1:0] label_now;
    lane_ctrl_t         ctrl;

    logic signed [SAMPLE_W-1:0] samples [8];
    feat_t                      feats [CHANNELS];

    // Configuration: a single register, written in the access phase of a transaction.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_width_reg <= WINDOW_WIDTH_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_WIDTH))
        begin
            window_width_reg <= pwdata[WIDTH_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WINDOW_WIDTH)
        begin
            prdata = {{(DATA_W - WIDTH_W){1'b0}}, window_width_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // Window tracking. A width of zero behaves as one, so every step closes a window.
    // The window closes at the first step whose position reaches width - 1, which also
    // covers a width that was lowered mid-window.
    always_comb
    begin
        width_eff = (window_width_reg == '0) ? WIDTH_W'(1) : window_width_reg;
        close     = ({1'b0, pos_reg} + 1'b1) >= {1'b0, width_eff};
        mid       = (pos_reg == (width_eff >> 1));
        label_now = mid ? class_label : held_label_reg;
        pos_next  = close ? '0 : pos_reg + 1'b1;
    end

    // A closing step needs the drain buffer; it may enter in the same cycle that the
    // last result of the previous window is taken.
    assign drain_free = !out_valid || (!out_stall && last);
    assign in_stall   = close && !drain_free;
    assign in_accept  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            held_label_reg <= '0;
        end
        else if (in_accept)
        begin
            pos_reg <= pos_next;
            if (mid)
            begin
                held_label_reg <= class_label;
            end
        end
    end

    always_comb
    begin
        ctrl.accept        = in_accept;
        ctrl.has_prev      = (pos_reg != '0);
        ctrl.has_prev_diff = (pos_reg > WIDTH_W'(1));
        ctrl.close         = close;
    end

    assign samples[0] = sample_ch0;
    assign samples[1] = sample_ch1;
    assign samples[2] = sample_ch2;
    assign samples[3] = sample_ch3;
    assign samples[4] = sample_ch4;
    assign samples[5] = sample_ch5;
    assign samples[6] = sample_ch6;
    assign samples[7] = sample_ch7;

    // One lane per channel, all updated by the same accepted step.
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        emg_td_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .sample (samples[c]),
            .result (feats[c])
        );
    end

    // The lane results of the closing step, including that step, go to the drain.
    emg_td_drain u_drain (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (in_accept && close),
        .feats            (feats),
        .label            (label_now),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .channel          (channel),
        .abs_sum          (abs_sum),
        .same_sign_count  (same_sign_count),
        .wave_length      (wave_length),
        .same_slope_count (same_slope_count),
        .window_label     (window_label),
        .last             (last)
    );

endmodule
`default_nettype wire

// ===== design/emg_td_checker.sv =====
// Port-level checks on the feature channel of the top level, and their binding.
`default_nettype none
module emg_td_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [emg_td_pkg::CHAN_W-1:0]      channel,
    input wire logic [emg_td_pkg::ABS_W-1:0]       abs_sum,
    input wire logic [emg_td_pkg::LABEL_W-1:0]     window_label,
    input wire logic                               last
);
    import emg_td_pkg::*;

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

    // A stalled result stays valid and holds its channel and abs_sum.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(channel) && $stable(abs_sum))
        else $error("stalled result changed");

    // The last flag marks exactly the final channel.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (channel == LAST_CHAN)))
        else $error("last flag does not match channel");

    // Within a window, results follow in channel order with one label.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && (channel == $past(channel) + 1'b1) && $stable(window_label))
        else $error("window results out of order");

    // A window whose results follow straight on the previous window's last result starts at channel zero.
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last ##1 out_valid |-> channel == '0)
        else $error("window did not start at channel zero");

endmodule

bind emg_time_domain_features emg_td_checker u_emg_td_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel      (channel),
    .abs_sum      (abs_sum),
    .window_label (window_label),
    .last         (last)
);
`default_nettype wire
